@@ rtl/core/smoothed_stroke_quad_expander_defines.svh @@
// assertion macros for the smoothed stroke quad expander
// used by the top level only; expects clk and rst_n in scope
`ifndef SMOOTHED_STROKE_QUAD_EXPANDER_DEFINES_SVH
`define SMOOTHED_STROKE_QUAD_EXPANDER_DEFINES_SVH

// same-cycle implication
`define SSQE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssqe check failed");

// next-cycle implication
`define SSQE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssqe check failed");

`endif

@@ rtl/core/ssqe_pkg.sv @@
// shared types and constants of the smoothed stroke quad expander
// no dependencies
package ssqe_pkg;

    localparam int unsigned NumW = 42;
    localparam int unsigned ResW = 21;
    localparam int unsigned RemW = 24;
    localparam int unsigned SqrtSteps = 21;
    localparam int unsigned DivSteps = 32;

    localparam logic [1:0] CfgStartWidth = 2'd0;
    localparam logic [1:0] CfgBaseWidth  = 2'd1;
    localparam logic [1:0] CfgGain       = 2'd2;
    localparam logic [1:0] CfgSmoothing  = 2'd3;

    localparam logic [15:0] StartWidthRst = 16'd512;
    localparam logic [15:0] BaseWidthRst  = 16'd384;
    localparam logic [15:0] GainRst       = 16'd13107;
    localparam logic [15:0] SmoothingRst  = 16'd19661;

    localparam logic [2:0] LastCorner = 3'd7;

    typedef struct packed {
        logic start;
        logic sqrt_mode;
    } unit_ctl_t;

    function automatic logic [4:0] tex_u_of(input logic [2:0] c);
        logic [4:0] u;
        case (c[2:1])
            2'd0:    u = 5'd0;
            2'd3:    u = 5'd16;
            default: u = 5'd8;
        endcase
        return u;
    endfunction

endpackage

@@ rtl/core/ssqe_root_div.sv @@
// shared restoring unit: integer square root (two bits a step) or division (one bit a step)
// depends on ssqe_pkg
module ssqe_root_div
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  ssqe_pkg::unit_ctl_t            ctl,
    input  logic [ssqe_pkg::NumW-1:0]      num,
    input  logic [ssqe_pkg::ResW-1:0]      divisor,
    output logic [ssqe_pkg::ResW-1:0]      res,
    output logic                           done
);

    logic [ssqe_pkg::NumW-1:0] num_reg, num_next;
    logic [ssqe_pkg::RemW-1:0] rem_reg, rem_next;
    logic [ssqe_pkg::ResW-1:0] res_reg, res_next;
    logic [5:0]                cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      mode_reg, mode_next;
    logic                      done_reg, done_next;
    logic [ssqe_pkg::RemW-1:0] shifted, trial;
    logic                      ge;

    // one compare-subtract, shared by both modes
    always_comb
    begin
        if (mode_reg)
        begin
            shifted = {rem_reg[ssqe_pkg::RemW-3:0], num_reg[ssqe_pkg::NumW-1 -: 2]};
            trial   = {1'b0, res_reg, 2'b01};
        end
        else
        begin
            shifted = {rem_reg[ssqe_pkg::RemW-2:0], num_reg[ssqe_pkg::NumW-1]};
            trial   = {3'b000, divisor};
        end
        ge = (shifted >= trial);
    end

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        mode_next = mode_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            num_next  = num;
            rem_next  = '0;
            res_next  = '0;
            mode_next = ctl.sqrt_mode;
            cnt_next  = ctl.sqrt_mode ? 6'(ssqe_pkg::SqrtSteps) : 6'(ssqe_pkg::DivSteps);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (shifted - trial) : shifted;
            res_next = {res_reg[ssqe_pkg::ResW-2:0], ge};
            num_next = mode_reg ? {num_reg[ssqe_pkg::NumW-3:0], 2'b00}
                                : {num_reg[ssqe_pkg::NumW-2:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            mode_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            mode_reg <= mode_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
    end

    assign res  = res_reg;
    assign done = done_reg;

endmodule

@@ rtl/core/smoothed_stroke_quad_expander.sv @@
// top level of the smoothed stroke quad expander
// depends on ssqe_pkg, ssqe_root_div and smoothed_stroke_quad_expander_defines.svh
`include "smoothed_stroke_quad_expander_defines.svh"

// Each input transfer is one stroke point (x, y in signed Q.4). A point that
// starts a stroke (action 1, or the first point after reset) is only stored,
// with start_width, and makes no output. Every later point makes one quad
// segment: eight vertex transfers, corner 0..7, with texture coordinates and
// the segment number. The width follows the point spacing, smoothed and
// saturated to 16 bits. The products, the square root and the divisions run
// through one multiplier and one shared restoring unit under a sequencer: two
// squares and the unit start, a 21-step square root, four width steps, then
// four offset divisions, each a product, a start and the 32-step divide (the
// divisions dominate); a zero-length segment skips the divisions. Emission is
// one vertex per cycle from a single output register while the receiver does
// not stall. in_stall stays high from the start of a segment until its last
// vertex is loaded; configuration writes take effect at once and should come
// only when idle.
module smoothed_stroke_quad_expander
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic signed [15:0] point_x,
    input  logic signed [15:0] point_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [17:0] vertex_x,
    output logic signed [17:0] vertex_y,
    output logic [2:0]         corner,
    output logic [4:0]         tex_u,
    output logic [4:0]         tex_v,
    output logic [15:0]        segment_index,
    output logic               last_vertex
);

    typedef enum logic [3:0] {
        S_IDLE, S_MULX, S_MULY, S_ROOT_GO, S_ROOT_WAIT, S_TGT, S_DIFF,
        S_SMO, S_WID, S_DMUL, S_DIV_GO, S_DIV_WAIT, S_EMIT
    } state_t;

    state_t state_reg;

    // configuration
    logic [15:0] start_width_reg, base_width_reg, gain_reg, smoothing_reg;

    // stroke state
    logic [15:0] prev_x_reg, prev_y_reg, prev_width_reg, seg_count_reg;
    logic        have_point_reg;

    // per-segment working registers
    logic signed [15:0] bx_reg, by_reg;
    logic signed [16:0] dx_reg, dy_reg;
    logic [33:0]        sq_reg;
    logic [20:0]        len_reg;
    logic [21:0]        target_reg, diff_reg;
    logic               up_reg;
    logic [37:0]        sprod_reg;
    logic [15:0]        wb_reg;
    logic [31:0]        dividend_reg;
    logic [1:0]         div_idx_reg;
    logic signed [13:0] off_reg [4];
    logic [2:0]         corner_reg;

    // output register
    logic               out_valid_reg;
    logic signed [17:0] vx_reg, vy_reg;
    logic [2:0]         oc_reg;
    logic [15:0]        oseg_reg;

    logic in_xfer, load;
    assign in_xfer  = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign load     = !out_valid_reg || !out_stall;

    // magnitudes of the direction
    logic [15:0] adx, ady;
    assign adx = dx_reg[16] ? 16'(-dx_reg) : dx_reg[15:0];
    assign ady = dy_reg[16] ? 16'(-dy_reg) : dy_reg[15:0];

    // shared multiplier, operands picked by the sequencer
    logic [21:0] mul_a;
    logic [16:0] mul_b;
    logic [38:0] prod;
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MULX:
            begin
                mul_a = 22'(adx);
                mul_b = 17'(adx);
            end
            S_MULY:
            begin
                mul_a = 22'(ady);
                mul_b = 17'(ady);
            end
            S_TGT:
            begin
                mul_a = 22'(len_reg);
                mul_b = 17'(gain_reg);
            end
            S_SMO:
            begin
                mul_a = diff_reg;
                mul_b = 17'(smoothing_reg);
            end
            S_DMUL:
            begin
                // p, q use the previous width, r, s the new one
                mul_a = 22'(div_idx_reg[0] ? ady : adx);
                mul_b = 17'(div_idx_reg[1] ? wb_reg : prev_width_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = 39'(mul_a) * 39'(mul_b);
    end

    // root / divide unit
    ssqe_pkg::unit_ctl_t unit_ctl;
    logic [41:0]         unit_num;
    logic [20:0]         unit_res;
    logic                unit_done;
    assign unit_ctl.start     = (state_reg == S_ROOT_GO) || (state_reg == S_DIV_GO);
    assign unit_ctl.sqrt_mode = (state_reg == S_ROOT_GO);
    assign unit_num = (state_reg == S_ROOT_GO) ? {sq_reg, 8'd0} : {dividend_reg, 10'd0};

    ssqe_root_div u_root_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (unit_ctl),
        .num     (unit_num),
        .divisor (len_reg),
        .res     (unit_res),
        .done    (unit_done)
    );

    // new width, saturated on the way up, rounded down on the way down
    logic [22:0] w_up;
    logic [38:0] w_dec;
    logic [15:0] w_new;
    always_comb
    begin
        w_up  = 23'(prev_width_reg) + 23'(sprod_reg[37:16]);
        w_dec = 39'(sprod_reg) + 39'd65535;
        if (up_reg)
            w_new = (w_up > 23'd65535) ? 16'hFFFF : w_up[15:0];
        else
            w_new = prev_width_reg - w_dec[31:16];
    end

    // signed quotient of the running division
    logic               div_neg;
    logic signed [13:0] div_q;
    assign div_neg = div_idx_reg[0] ? dy_reg[16] : dx_reg[16];
    assign div_q   = div_neg ? -$signed(unit_res[13:0]) : $signed(unit_res[13:0]);

    // vertex of the current corner
    logic signed [17:0] ax, ay, bx, by, p, q, r, s, vx, vy;
    always_comb
    begin
        ax = 18'(signed'(prev_x_reg));
        ay = 18'(signed'(prev_y_reg));
        bx = 18'(bx_reg);
        by = 18'(by_reg);
        p  = 18'(off_reg[0]);
        q  = 18'(off_reg[1]);
        r  = 18'(off_reg[2]);
        s  = 18'(off_reg[3]);
        case (corner_reg)
            3'd0:
            begin
                vx = ax + q - p;
                vy = ay - p - q;
            end
            3'd1:
            begin
                vx = ax - q - p;
                vy = ay + p - q;
            end
            3'd2:
            begin
                vx = ax + q;
                vy = ay - p;
            end
            3'd3:
            begin
                vx = ax - q;
                vy = ay + p;
            end
            3'd4:
            begin
                vx = bx + s;
                vy = by - r;
            end
            3'd5:
            begin
                vx = bx - s;
                vy = by + r;
            end
            3'd6:
            begin
                vx = bx + r + s;
                vy = by + s - r;
            end
            default:
            begin
                vx = bx + r - s;
                vy = by + r + s;
            end
        endcase
    end

    // sequencer, stroke state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            start_width_reg <= ssqe_pkg::StartWidthRst;
            base_width_reg  <= ssqe_pkg::BaseWidthRst;
            gain_reg        <= ssqe_pkg::GainRst;
            smoothing_reg   <= ssqe_pkg::SmoothingRst;
            prev_x_reg      <= '0;
            prev_y_reg      <= '0;
            prev_width_reg  <= '0;
            seg_count_reg   <= '0;
            have_point_reg  <= 1'b0;
            div_idx_reg     <= '0;
            corner_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ssqe_pkg::CfgStartWidth: start_width_reg <= cfg_data;
                    ssqe_pkg::CfgBaseWidth:  base_width_reg  <= cfg_data;
                    ssqe_pkg::CfgGain:       gain_reg        <= cfg_data;
                    ssqe_pkg::CfgSmoothing:  smoothing_reg   <= cfg_data;
                    default:                 ;
                endcase
            end

            // output holds until taken, reloads while emitting
            if (state_reg == S_EMIT && load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if (action || !have_point_reg)
                        begin
                            // new stroke: remember the point only
                            prev_x_reg     <= point_x;
                            prev_y_reg     <= point_y;
                            prev_width_reg <= start_width_reg;
                            seg_count_reg  <= '0;
                            have_point_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_MULX;
                        end
                    end
                end
                S_MULX:      state_reg <= S_MULY;
                S_MULY:      state_reg <= S_ROOT_GO;
                S_ROOT_GO:   state_reg <= S_ROOT_WAIT;
                S_ROOT_WAIT:
                begin
                    if (unit_done)
                        state_reg <= S_TGT;
                end
                S_TGT:       state_reg <= S_DIFF;
                S_DIFF:      state_reg <= S_SMO;
                S_SMO:       state_reg <= S_WID;
                S_WID:
                begin
                    div_idx_reg <= '0;
                    corner_reg  <= '0;
                    // zero-length segment: no division, offsets stay zero
                    state_reg   <= (len_reg == '0) ? S_EMIT : S_DMUL;
                end
                S_DMUL:      state_reg <= S_DIV_GO;
                S_DIV_GO:    state_reg <= S_DIV_WAIT;
                S_DIV_WAIT:
                begin
                    if (unit_done)
                    begin
                        div_idx_reg <= div_idx_reg + 2'd1;
                        state_reg   <= (div_idx_reg == 2'd3) ? S_EMIT : S_DMUL;
                    end
                end
                S_EMIT:
                begin
                    if (load)
                    begin
                        corner_reg <= corner_reg + 3'd1;
                        if (corner_reg == ssqe_pkg::LastCorner)
                        begin
                            prev_x_reg     <= bx_reg;
                            prev_y_reg     <= by_reg;
                            prev_width_reg <= wb_reg;
                            seg_count_reg  <= seg_count_reg + 16'd1;
                            state_reg      <= S_IDLE;
                        end
                    end
                end
                default:     state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            bx_reg <= point_x;
            by_reg <= point_y;
            dx_reg <= 17'(point_x) - 17'(signed'(prev_x_reg));
            dy_reg <= 17'(point_y) - 17'(signed'(prev_y_reg));
        end
        case (state_reg)
            S_MULX: sq_reg <= prod[33:0];
            S_MULY: sq_reg <= sq_reg + prod[33:0];
            S_ROOT_WAIT:
            begin
                if (unit_done)
                    len_reg <= unit_res;
            end
            S_TGT:  target_reg <= 22'(base_width_reg) + prod[37:16];
            S_DIFF:
            begin
                up_reg   <= (target_reg >= 22'(prev_width_reg));
                diff_reg <= (target_reg >= 22'(prev_width_reg))
                            ? target_reg - 22'(prev_width_reg)
                            : 22'(prev_width_reg) - target_reg;
            end
            S_SMO:  sprod_reg <= prod[37:0];
            S_WID:
            begin
                wb_reg     <= w_new;
                off_reg[0] <= '0;
                off_reg[1] <= '0;
                off_reg[2] <= '0;
                off_reg[3] <= '0;
            end
            S_DMUL: dividend_reg <= prod[31:0];
            S_DIV_WAIT:
            begin
                if (unit_done)
                    off_reg[div_idx_reg] <= div_q;
            end
            S_EMIT:
            begin
                if (load)
                begin
                    vx_reg   <= vx;
                    vy_reg   <= vy;
                    oc_reg   <= corner_reg;
                    oseg_reg <= seg_count_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign vertex_x      = vx_reg;
    assign vertex_y      = vy_reg;
    assign corner        = oc_reg;
    assign tex_u         = ssqe_pkg::tex_u_of(oc_reg);
    assign tex_v         = oc_reg[0] ? 5'd16 : 5'd0;
    assign segment_index = oseg_reg;
    assign last_vertex   = (oc_reg == ssqe_pkg::LastCorner);

    // a segment is only ever built from a stored point
    `SSQE_ASSERT_NOW(a_emit_has_point, state_reg == S_EMIT, have_point_reg)
    // the shared unit only finishes while the sequencer waits on it
    `SSQE_ASSERT_NOW(a_done_when_waiting, unit_done,
        state_reg == S_ROOT_WAIT || state_reg == S_DIV_WAIT)
    // the last corner returns the sequencer to idle
    `SSQE_ASSERT_NEXT(a_last_to_idle,
        state_reg == S_EMIT && load && corner_reg == ssqe_pkg::LastCorner,
        state_reg == S_IDLE && out_valid_reg)

endmodule

@@ dv/smoothed_stroke_quad_expander_tb.sv @@
// self-checking testbench of the smoothed stroke quad expander
// depends on ssqe_pkg and the smoothed_stroke_quad_expander top level
module smoothed_stroke_quad_expander_tb;

    localparam int unsigned RandomPoints = 385;
    localparam int unsigned QuietTail = 60;
    localparam int unsigned IdleLimit = 5000;
    localparam int unsigned SettleCycles = 12;

    // one vertex of a segment quad, as the block should send it
    typedef struct {
        logic [17:0] vx;
        logic [17:0] vy;
        logic [2:0]  crn;
        logic [4:0]  tu;
        logic [4:0]  tv;
        logic [15:0] seg;
        logic        last;
    } vertex_t;

    // one row of the directed stimulus: a register write or a stroke point
    typedef struct {
        bit          is_cfg;
        logic [1:0]  idx;
        logic [15:0] data;
        bit          act;
        logic [15:0] px;
        logic [15:0] py;
        bit          zero_len;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic               action;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic               out_valid;
    logic               out_stall;
    logic signed [17:0] vertex_x;
    logic signed [17:0] vertex_y;
    logic [2:0]         corner;
    logic [4:0]         tex_u;
    logic [4:0]         tex_v;
    logic [15:0]        segment_index;
    logic               last_vertex;

    smoothed_stroke_quad_expander dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .point_x       (point_x),
        .point_y       (point_y),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .vertex_x      (vertex_x),
        .vertex_y      (vertex_y),
        .corner        (corner),
        .tex_u         (tex_u),
        .tex_v         (tex_v),
        .segment_index (segment_index),
        .last_vertex   (last_vertex)
    );

    // shadow of the configuration registers
    logic [15:0] start_w;
    logic [15:0] base_w;
    logic [15:0] gain;
    logic [15:0] smooth;

    // shadow of the stroke state
    logic signed [15:0] last_x;
    logic signed [15:0] last_y;
    logic [15:0]        last_w;
    logic [15:0]        seg_count;
    bit                 stroke_open;

    vertex_t vertex_q[$];
    int      errors;
    bit      quiet;
    int      idle_cycles;

    // integer square root, bit by bit
    function automatic longint unsigned root64(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // width-scaled direction component, truncated toward zero
    function automatic int scaled_dir(input int d, input longint unsigned w,
                                      input longint unsigned len);
        longint unsigned mag;
        if (len == 0)
            return 0;
        mag = (longint'(d < 0 ? -d : d) * w) / len;
        return d < 0 ? -int'(mag) : int'(mag);
    endfunction

    // advance the stroke shadow by one point and queue the quad it makes;
    // with zero_len the vertices are typed in as the point itself
    function automatic void stroke_point(input bit act, input logic signed [15:0] bx,
                                         input logic signed [15:0] by, input bit zero_len);
        int vx[8];
        int vy[8];
        int tu_of[8];
        int dx;
        int dy;
        int p;
        int q;
        int r;
        int s;
        longint unsigned len;
        longint unsigned tgt;
        longint unsigned wn;
        vertex_t v;
        tu_of = '{0, 0, 8, 8, 8, 8, 16, 16};
        if (act || !stroke_open)
        begin
            last_x = bx;
            last_y = by;
            last_w = start_w;
            seg_count = 0;
            stroke_open = 1;
            return;
        end
        dx = int'(bx) - int'(last_x);
        dy = int'(by) - int'(last_y);
        len = root64((longint'(dx) * dx + longint'(dy) * dy) << 8);
        tgt = base_w + ((len * gain) >> 16);
        if (tgt >= last_w)
            wn = last_w + (((tgt - last_w) * smooth) >> 16);
        else
            wn = last_w - (((last_w - tgt) * smooth + 65535) >> 16);
        if (wn > 65535)
            wn = 65535;
        p = scaled_dir(dx, last_w, len);
        q = scaled_dir(dy, last_w, len);
        r = scaled_dir(dx, wn, len);
        s = scaled_dir(dy, wn, len);
        vx[0] = last_x + q - p; vy[0] = last_y - p - q;
        vx[1] = last_x - q - p; vy[1] = last_y + p - q;
        vx[2] = last_x + q;     vy[2] = last_y - p;
        vx[3] = last_x - q;     vy[3] = last_y + p;
        vx[4] = bx + s;         vy[4] = by - r;
        vx[5] = bx - s;         vy[5] = by + r;
        vx[6] = bx + r + s;     vy[6] = by + s - r;
        vx[7] = bx + r - s;     vy[7] = by + r + s;
        for (int k = 0; k < 8; k++)
        begin
            if (zero_len)
            begin
                v.vx = k < 4 ? 18'(last_x) : 18'(bx);
                v.vy = k < 4 ? 18'(last_y) : 18'(by);
            end
            else
            begin
                v.vx = vx[k][17:0];
                v.vy = vy[k][17:0];
            end
            v.crn = 3'(k);
            v.tu = 5'(tu_of[k]);
            v.tv = (k & 1) ? 5'd16 : 5'd0;
            v.seg = seg_count;
            v.last = (3'(k) == ssqe_pkg::LastCorner);
            vertex_q = {vertex_q, v};
        end
        last_x = bx;
        last_y = by;
        last_w = 16'(wn);
        seg_count = seg_count + 16'd1;
    endfunction

    // clock and reset
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n <= 0;
        cfg_we <= 0;
        cfg_index <= ssqe_pkg::CfgStartWidth;
        cfg_data <= 0;
        in_valid <= 0;
        action <= 0;
        point_x <= 0;
        point_y <= 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
    end

    // receiver stalls in short random bursts, none in the quiet tail
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_stall <= 0;
        forever
        begin
            @(posedge clk);
            if (quiet)
                out_stall <= 0;
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                out_stall <= 1;
            end
            else
                out_stall <= 0;
        end
    end

    // vertex checker: every output transfer against the oldest expectation
    always @(posedge clk)
    begin
        vertex_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (vertex_q.size() == 0)
            begin
                $display("%0t: unexpected vertex x=%0d y=%0d corner=%0d",
                         $time, vertex_x, vertex_y, corner);
                errors++;
            end
            else
            begin
                e = vertex_q.pop_front();
                if (vertex_x !== e.vx || vertex_y !== e.vy || corner !== e.crn ||
                    tex_u !== e.tu || tex_v !== e.tv || segment_index !== e.seg ||
                    last_vertex !== e.last)
                begin
                    $display("%0t: vertex mismatch expected x=%0d y=%0d c=%0d u=%0d v=%0d seg=%0d last=%0d",
                             $time, $signed(e.vx), $signed(e.vy), e.crn, e.tu, e.tv,
                             e.seg, e.last);
                    $display("%0t:                 actual x=%0d y=%0d c=%0d u=%0d v=%0d seg=%0d last=%0d",
                             $time, vertex_x, vertex_y, corner, tex_u, tex_v,
                             segment_index, last_vertex);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("smoothed_stroke_quad_expander verification failed");
            $finish;
        end
    end

    // one point transfer, with an optional idle burst in front of it
    task automatic send_point(input bit act, input logic [15:0] x, input logic [15:0] y,
                              input bit zero_len);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        action <= act;
        point_x <= x;
        point_y <= y;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        stroke_point(act, x, y, zero_len);
    endtask

    // register write once all vertices are out and a stroke start has settled
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        in_valid <= 0;
        while (vertex_q.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        case (idx)
            ssqe_pkg::CfgStartWidth: start_w = val;
            ssqe_pkg::CfgBaseWidth:  base_w = val;
            ssqe_pkg::CfgGain:       gain = val;
            default:                 smooth = val;
        endcase
    endtask

    function automatic logic [15:0] pick_reg_value();
        case ($urandom_range(0, 4))
            0:       return 16'd0;
            1:       return 16'hffff;
            2:       return 16'($urandom_range(0, 1023));
            default: return 16'($urandom);
        endcase
    endfunction

    row_t rows[$];

    function automatic row_t pt(input bit act, input int x, input int y, input bit z);
        row_t r;
        r = '{default: 0};
        r.act = act;
        r.px = 16'(x);
        r.py = 16'(y);
        r.zero_len = z;
        return r;
    endfunction

    function automatic row_t wr(input logic [1:0] idx, input logic [15:0] val);
        row_t r;
        r = '{default: 0};
        r.is_cfg = 1;
        r.idx = idx;
        r.data = val;
        return r;
    endfunction

    initial
    begin
        logic [15:0] x;
        logic [15:0] y;
        bit act;
        int kind;
        errors = 0;
        quiet = 0;
        idle_cycles = 0;
        start_w = ssqe_pkg::StartWidthRst;
        base_w = ssqe_pkg::BaseWidthRst;
        gain = ssqe_pkg::GainRst;
        smooth = ssqe_pkg::SmoothingRst;
        last_x = 0;
        last_y = 0;
        last_w = 0;
        seg_count = 0;
        stroke_open = 0;

        // append with no point yet opens a stroke; zero-length segments are typed
        rows = {rows, pt(0, 0, 0, 0)};
        rows = {rows, pt(0, 0, 0, 1)};
        rows = {rows, pt(0, 160, 0, 0)};
        rows = {rows, pt(0, 160, -160, 0)};
        rows = {rows, pt(1, 32767, 32767, 0)};
        rows = {rows, pt(0, -32768, -32768, 0)};
        rows = {rows, pt(0, -32768, -32768, 1)};
        // width saturation with gain, base width and smoothing at their top
        rows = {rows, wr(ssqe_pkg::CfgGain, 16'hffff)};
        rows = {rows, wr(ssqe_pkg::CfgBaseWidth, 16'hffff)};
        rows = {rows, wr(ssqe_pkg::CfgSmoothing, 16'hffff)};
        rows = {rows, pt(1, 0, 0, 0)};
        rows = {rows, pt(0, 32767, -32768, 0)};
        rows = {rows, pt(0, -32768, 32767, 0)};
        // zero widths, unit steps
        rows = {rows, wr(ssqe_pkg::CfgStartWidth, 16'd0)};
        rows = {rows, wr(ssqe_pkg::CfgSmoothing, 16'd0)};
        rows = {rows, pt(1, 5, 5, 0)};
        rows = {rows, pt(0, 6, 5, 0)};
        rows = {rows, pt(0, 5, 6, 0)};
        // wide start shrinking toward a zero target
        rows = {rows, wr(ssqe_pkg::CfgStartWidth, 16'hffff)};
        rows = {rows, wr(ssqe_pkg::CfgBaseWidth, 16'd0)};
        rows = {rows, wr(ssqe_pkg::CfgGain, 16'd0)};
        rows = {rows, wr(ssqe_pkg::CfgSmoothing, ssqe_pkg::SmoothingRst)};
        rows = {rows, pt(1, -100, 50, 0)};
        rows = {rows, pt(0, 100, -50, 0)};
        rows = {rows, pt(0, 100, -50, 1)};

        @(posedge clk);
        while (!rst_n)
            @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
                write_reg(rows[i].idx, rows[i].data);
            else
                send_point(rows[i].act, rows[i].px, rows[i].py, rows[i].zero_len);
        end

        // random strokes: mostly appends near the last point, some far jumps
        for (int n = 0; n < RandomPoints; n++)
        begin
            if (n == RandomPoints - QuietTail)
                quiet = 1;
            if (n % 90 == 0)
            begin
                write_reg(ssqe_pkg::CfgStartWidth, pick_reg_value());
                write_reg(ssqe_pkg::CfgBaseWidth, pick_reg_value());
                write_reg(ssqe_pkg::CfgGain, pick_reg_value());
                write_reg(ssqe_pkg::CfgSmoothing, pick_reg_value());
            end
            act = ($urandom_range(0, 15) == 0);
            kind = $urandom_range(0, 9);
            if (kind < 6)
            begin
                x = 16'(last_x) + 16'($urandom_range(0, 255)) - 16'd128;
                y = 16'(last_y) + 16'($urandom_range(0, 255)) - 16'd128;
            end
            else if (kind < 9)
            begin
                x = 16'($urandom);
                y = 16'($urandom);
            end
            else
            begin
                // repeat the last point for a zero-length segment
                x = last_x;
                y = last_y;
            end
            send_point(act, x, y, 0);
        end
        in_valid <= 0;

        while (vertex_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("smoothed_stroke_quad_expander verification clean");
        else
            $display("smoothed_stroke_quad_expander verification failed");
        $finish;
    end

endmodule
